[rtl/inode_location_calculator_defines.svh]
// Assertion macros for the inode location calculator.
`ifndef INODE_LOCATION_CALCULATOR_DEFINES_SVH
`define INODE_LOCATION_CALCULATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define ILC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ILC assertion failed");

// Next-cycle implication, disabled while in reset.
`define ILC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ILC assertion failed");

`else

`define ILC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define ILC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/ilc_pkg.sv]
// Shared types, constants and codes for the inode location calculator.
package ilc_pkg;

    localparam int MAX_GROUPS_DEF       = 256;
    localparam int LOG_SECTOR_BYTES_DEF = 9;
    localparam int LOG_INODE_BYTES_DEF  = 7;
    localparam int FS_BLOCK_BASE_LOG    = 10;

    localparam int INUM_W  = 32;
    localparam int DIV_W   = 17;
    localparam int BLOCK_W = 32;
    localparam int SECT_W  = 32;
    localparam int BYTE_W  = 9;
    localparam int LOGB_W  = 3;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INODES_TOTAL      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INODES_PER_GROUP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_FS_BLOCK_SIZE = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_GROUP = 2'd2;

    typedef struct packed {
        logic               opcode;
        logic [7:0]         group_index;
        logic [BLOCK_W-1:0] table_start_block;
        logic [INUM_W-1:0]  inode_number;
    } in_item_t;

    typedef struct packed {
        logic [SECT_W-1:0] sector_address;
        logic [BYTE_W-1:0] byte_in_sector;
        logic [1:0]        status;
    } out_item_t;

endpackage

[rtl/ilc_divider.sv]
// Restoring divider, one quotient bit per cycle through a shift register.
module ilc_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ilc_pkg::INUM_W-1:0] dividend,
    input  logic [ilc_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [ilc_pkg::INUM_W-1:0] quotient,
    output logic [ilc_pkg::DIV_W-1:0]  remainder
);
    import ilc_pkg::*;

    localparam int CNT_W = $clog2(INUM_W + 1);

    logic [INUM_W-1:0] dq_reg, dq_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_W:0]    shifted;
    logic [DIV_W:0]    diff;
    logic              ge;

    always_comb
    begin
        shifted = {rem_reg, dq_reg[INUM_W-1]};
        ge      = shifted >= {1'b0, dvs_reg};
        diff    = shifted - {1'b0, dvs_reg};

        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(INUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            dq_next  = {dq_reg[INUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = dq_reg;
    assign remainder = rem_reg;

endmodule

[rtl/ilc_group_table.sv]
// Group table memory: inode table start block per group, registered read.
module ilc_group_table
#(
    parameter int MAX_GROUPS = ilc_pkg::MAX_GROUPS_DEF,
    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
)
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ilc_pkg::BLOCK_W-1:0] wr_data,
    input  logic                        re,
    input  logic [AW-1:0]               rd_addr,
    output logic [ilc_pkg::BLOCK_W-1:0] rd_data
);
    import ilc_pkg::*;

    logic [BLOCK_W-1:0] mem [MAX_GROUPS];
    logic [BLOCK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/inode_location_calculator.sv]
// Locate request: 32 divide steps, done flag, table read, result register, in that order.
// Out-of-range inode numbers skip the divider and table read. Load requests write the table and give no output.
// One locate request in flight; the restoring divider sets the rate, and no new request is taken until FINISH is left.
// A new request is taken while the previous result still waits in the output register.
// Reset (async, active low) resets control and config registers; table contents stay
// undefined until loaded, and no clearing pass runs.
module inode_location_calculator
#(
    parameter int MAX_GROUPS       = ilc_pkg::MAX_GROUPS_DEF,
    parameter int LOG_SECTOR_BYTES = ilc_pkg::LOG_SECTOR_BYTES_DEF,
    parameter int LOG_INODE_BYTES  = ilc_pkg::LOG_INODE_BYTES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  ilc_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ilc_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [ilc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ilc_pkg::CFG_W-1:0]     cfg_data
);
    import ilc_pkg::*;

    `include "inode_location_calculator_defines.svh"

    localparam int AW         = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int OW         = DIV_W + LOG_INODE_BYTES;
    localparam int BASE_SHIFT = FS_BLOCK_BASE_LOG - LOG_SECTOR_BYTES;

    typedef enum logic [2:0]
    {
        S_IDLE   = 3'b001,
        S_DIV    = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [INUM_W-1:0] itotal_reg;
    logic [DIV_W-1:0]  ipg_reg;
    logic [LOGB_W-1:0] logb_reg;
    logic [1:0]        status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              accept;
    logic              div_start;
    logic              div_done;
    logic [INUM_W-1:0] div_quot;
    logic [DIV_W-1:0]  div_rem;
    logic [DIV_W-1:0]  div_eff;

    logic              tbl_we;
    logic              tbl_re;
    logic [16:0]       gidx_ext;
    logic [AW-1:0]     tbl_wr_addr;
    logic [AW-1:0]     tbl_rd_addr;
    logic [BLOCK_W-1:0] tbl_rd_data;

    logic [OW-1:0]     offset;
    logic [OW-1:0]     offset_sec;
    logic [4:0]        shamt;
    logic [SECT_W-1:0] sector;
    logic              out_free;

    logic              out_err;
    logic              out_zero;
    logic              locate_acc;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign div_eff     = (ipg_reg == '0) ? DIV_W'(1) : ipg_reg;
    assign gidx_ext    = {9'b0, in_data.group_index};
    assign tbl_wr_addr = gidx_ext[AW-1:0];
    assign tbl_rd_addr = div_quot[AW-1:0];
    assign out_free    = !out_valid_reg || !out_stall;

    // Address arithmetic, evaluated while the table entry is held in FINISH.
    assign offset     = {div_rem, {LOG_INODE_BYTES{1'b0}}};
    assign offset_sec = offset >> LOG_SECTOR_BYTES;
    assign shamt      = 5'(BASE_SHIFT) + {2'b0, logb_reg};
    assign sector     = (tbl_rd_data << shamt) + SECT_W'(offset_sec);

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        div_start      = 1'b0;
        tbl_we         = 1'b0;
        tbl_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.opcode == OP_LOAD)
                    begin
                        tbl_we = (gidx_ext < 17'(MAX_GROUPS));
                    end
                    else if (in_data.inode_number == '0 ||
                             in_data.inode_number > itotal_reg)
                    begin
                        status_next = STATUS_RANGE;
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_quot >= INUM_W'(MAX_GROUPS))
                    begin
                        status_next = STATUS_GROUP;
                    end
                    else
                    begin
                        status_next = STATUS_OK;
                        tbl_re      = 1'b1;
                    end
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = status_reg;
                    if (status_reg == STATUS_OK)
                    begin
                        out_data_next.sector_address = sector;
                        out_data_next.byte_in_sector = offset[BYTE_W-1:0];
                    end
                    else
                    begin
                        out_data_next.sector_address = '0;
                        out_data_next.byte_in_sector = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            itotal_reg    <= '0;
            ipg_reg       <= DIV_W'(1);
            logb_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INODES_TOTAL:      itotal_reg <= cfg_data[INUM_W-1:0];
                    CFG_INODES_PER_GROUP:  ipg_reg    <= cfg_data[DIV_W-1:0];
                    CFG_LOG_FS_BLOCK_SIZE: logb_reg   <= cfg_data[LOGB_W-1:0];
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    ilc_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (in_data.inode_number - INUM_W'(1)),
        .divisor   (div_eff),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    ilc_group_table #(.MAX_GROUPS(MAX_GROUPS)) u_table
    (
        .clk     (clk),
        .we      (tbl_we),
        .wr_addr (tbl_wr_addr),
        .wr_data (in_data.table_start_block),
        .re      (tbl_re),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    assign out_err    = out_valid && out_data.status != STATUS_OK;
    assign out_zero   = out_data.sector_address == '0 && out_data.byte_in_sector == '0;
    assign locate_acc = accept && in_data.opcode == OP_LOCATE;

    `ILC_ASSERT_NOW(a_done_in_div, clk, rst_n, div_done, state_reg == S_DIV)
    `ILC_ASSERT_NOW(a_err_zero, clk, rst_n, out_err, out_zero)
    `ILC_ASSERT_NEXT(a_locate_busy, clk, rst_n, locate_acc, state_reg != S_IDLE)

endmodule
